// ----- rtl/trb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trb_pkg
// Shared widths, constants, angle table and word types of the range and
// bearing pipeline.
// ----------------------------------------------------------------------------
package trb_pkg;

    localparam int CORDIC_ITERATIONS = 24;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
    localparam int SQ_STEPS          = 32;
    localparam int SQ_TOP            = 62;
    localparam int XW                = 36;
    localparam int AW                = 34;
    localparam int ANG_DROP          = 8;
    localparam int ANG_HALF          = 128;
    localparam int ANGLE_360_Q16     = 23592960;

    localparam logic signed [AW-1:0] ANGLE_180_Q24 = 34'sd3019898880;

    localparam logic [29:0] ATAN_Q24 [32] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
        30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
        30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
        30'd234684,    30'd117342,    30'd58671,     30'd29335,
        30'd14668,     30'd7334,      30'd3667,      30'd1833,
        30'd917,       30'd458,       30'd229,       30'd115,
        30'd57,        30'd29,        30'd14,        30'd7,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    typedef enum logic [1:0] {
        CFG_CENTER_X       = 2'd0,
        CFG_CENTER_Y       = 2'd1,
        CFG_RADIUS_SQUARED = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [AW-1:0] ang;
        logic                 zero;
    } t_cord;

    typedef struct packed {
        logic                 valid;
        logic                 in_circle;
        logic [63:0]          d2;
        logic [63:0]          sq_n;
        logic [63:0]          sq_r;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [AW-1:0] ang;
        logic                 zero;
    } t_word;

    typedef struct packed {
        logic        in_circle;
        logic [62:0] d2;
        logic [31:0] root;
        logic [24:0] bear;
    } t_res;

endpackage
`default_nettype wire

// ----- rtl/trb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trb_front
// Five-stage front end: saturated deltas, squares, scaled radius product,
// membership compare and rotator set-up for the cell chain.
// ----------------------------------------------------------------------------
module trb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic [15:0]        i_expansion,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic [62:0]        i_radius_squared,
    output trb_pkg::t_word     o_w
);
    import trb_pkg::*;

    logic               r1_valid, r2_valid, r3_valid, r4_valid;
    logic signed [31:0] r1_dx, r1_dy;
    logic [15:0]        r1_e;
    logic [63:0]        r2_ax2, r2_ay2;
    logic [31:0]        r2_e2;
    t_cord              r2_c, r3_c, r4_c;
    logic [63:0]        r3_d2, r4_d2;
    logic [62:0]        r3_ah;
    logic [63:0]        r3_bl;
    logic [94:0]        r4_rp;
    t_word              r_w;

    logic signed [32:0] n_dx_w, n_dy_w;
    logic signed [31:0] n_dx, n_dy;
    logic [31:0]        n_ax, n_ay;
    t_cord              n_c;
    logic signed [XW-1:0] n_x_ext, n_y_ext;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    always_comb begin
        n_dx_w  = 33'(i_center_x) - 33'(i_pos_x);
        n_dy_w  = 33'(i_center_y) - 33'(i_pos_y);
        n_dx    = sat32(n_dx_w);
        n_dy    = sat32(n_dy_w);
        n_ax    = r1_dx[31] ? 32'(-r1_dx) : 32'(r1_dx);
        n_ay    = r1_dy[31] ? 32'(-r1_dy) : 32'(r1_dy);
        n_x_ext = XW'(r1_dx);
        n_y_ext = XW'(r1_dy);
        n_c.x    = r1_dx[31] ? -n_x_ext : n_x_ext;
        n_c.y    = r1_dx[31] ? -n_y_ext : n_y_ext;
        n_c.ang  = r1_dx[31] ? ANGLE_180_Q24 : '0;
        n_c.zero = (r1_dx == 32'sd0) && (r1_dy == 32'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_w.valid   <= 1'b0;
        end else if (i_en) begin
            r1_valid    <= i_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r_w.valid   <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // delta stage
            r1_dx      <= n_dx;
            r1_dy      <= n_dy;
            r1_e       <= i_expansion;
            // squares and rotator set-up
            r2_ax2     <= 64'(n_ax) * 64'(n_ax);
            r2_ay2     <= 64'(n_ay) * 64'(n_ay);
            r2_e2      <= 32'(r1_e) * 32'(r1_e);
            r2_c       <= n_c;
            // distance sum and radius partial products
            r3_d2      <= r2_ax2 + r2_ay2;
            r3_ah      <= 63'(i_radius_squared[62:32]) * 63'(r2_e2);
            r3_bl      <= 64'(i_radius_squared[31:0]) * 64'(r2_e2);
            r3_c       <= r2_c;
            // radius product
            r4_rp      <= 95'({r3_ah, 32'd0}) + 95'(r3_bl);
            r4_d2      <= r3_d2;
            r4_c       <= r3_c;
            // membership compare
            r_w.in_circle <= 95'({r4_d2, 24'd0}) <= r4_rp;
            r_w.d2     <= r4_d2;
            r_w.sq_n   <= r4_d2;
            r_w.sq_r   <= '0;
            r_w.x      <= r4_c.x;
            r_w.y      <= r4_c.y;
            r_w.ang    <= r4_c.ang;
            r_w.zero   <= r4_c.zero;
        end
    end

    assign o_w = r_w;

endmodule
`default_nettype wire

// ----- rtl/trb_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trb_cell
// One cell of the chain: one square-root digit step and, for an index below
// CORDIC_STEPS, one vectoring rotation step, registered.
// ----------------------------------------------------------------------------
module trb_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [4:0]     i_idx,
    input  trb_pkg::t_word i_w,
    output trb_pkg::t_word o_w
);
    import trb_pkg::*;

    t_word                r_w;
    t_word                n_w;
    logic [5:0]           sq_sh;
    logic [63:0]          sq_bit;
    logic [63:0]          sq_trial;
    logic signed [XW-1:0] xs, ys;
    logic signed [AW-1:0] da;

    always_comb begin
        n_w      = i_w;
        sq_sh    = 6'(SQ_TOP) - {i_idx, 1'b0};
        sq_bit   = 64'd1 << sq_sh;
        sq_trial = i_w.sq_r + sq_bit;
        if (i_w.sq_n >= sq_trial) begin
            n_w.sq_n = i_w.sq_n - sq_trial;
            n_w.sq_r = (i_w.sq_r >> 1) + sq_bit;
        end else begin
            n_w.sq_r = i_w.sq_r >> 1;
        end
        xs = $signed(i_w.x) >>> i_idx;
        ys = $signed(i_w.y) >>> i_idx;
        da = $signed({{(AW-30){1'b0}}, ATAN_Q24[i_idx]});
        if ({1'b0, i_idx} < 6'(CORDIC_STEPS)) begin
            if (!i_w.y[XW-1]) begin
                n_w.x   = i_w.x + ys;
                n_w.y   = i_w.y - xs;
                n_w.ang = i_w.ang + da;
            end else begin
                n_w.x   = i_w.x - ys;
                n_w.y   = i_w.y + xs;
                n_w.ang = i_w.ang - da;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w.valid <= 1'b0;
        end else if (i_en) begin
            r_w <= n_w;
        end
    end

    assign o_w = r_w;

endmodule
`default_nettype wire

// ----- rtl/trb_out.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trb_out
// Bearing rounding and wrap, squared distance clamp, and a two-word output
// queue that sets the pipeline advance.
// ----------------------------------------------------------------------------
module trb_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  trb_pkg::t_word i_w,
    output logic           o_adv,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [127:0]   o_data
);
    import trb_pkg::*;

    logic                 r_b_valid;
    t_res                 r_b;
    t_res                 n_b;
    t_res                 r_q0, r_q1;
    logic [1:0]           r_cnt;
    logic signed [AW-1:0] ang_r, ang_q;
    logic signed [25:0]   b26;
    logic [25:0]          bw;
    logic                 push, pop;

    always_comb begin
        ang_r = i_w.ang + AW'(ANG_HALF);
        ang_q = ang_r >>> ANG_DROP;
        b26   = $signed(ang_q[25:0]);
        if (b26[25]) begin
            bw = b26 + 26'(ANGLE_360_Q16);
        end else if (b26 >= 26'(ANGLE_360_Q16)) begin
            bw = b26 - 26'(ANGLE_360_Q16);
        end else begin
            bw = b26;
        end
        n_b.in_circle = i_w.in_circle;
        n_b.d2        = i_w.d2[63] ? {63{1'b1}} : i_w.d2[62:0];
        n_b.root      = i_w.sq_r[31:0];
        n_b.bear      = i_w.zero ? 25'd0 : bw[24:0];
    end

    assign o_adv   = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = o_adv && r_b_valid;
    assign pop     = o_valid && i_ready;
    assign o_data  = {7'd0, r_q0.bear, r_q0.root, r_q0.d2, r_q0.in_circle};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (o_adv) begin
            r_b_valid <= i_w.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_b <= n_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (push && !pop) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (pop && !push) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && !pop) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= r_b;
            end else begin
                r_q1 <= r_b;
            end
        end else if (pop && !push) begin
            r_q0 <= r_q1;
        end else if (pop && push) begin
            if (r_cnt == 2'd1) begin
                r_q0 <= r_b;
            end else begin
                r_q0 <= r_q1;
                r_q1 <= r_b;
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_adv && r_b_valid) |=> r_b_valid)
        else $error("formatted word lost while stalled");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> (r_cnt == 2'd2))
        else $error("full queue changed without a pop");

    a_bear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_q0.bear < 25'(ANGLE_360_Q16)))
        else $error("bearing outside one turn");

endmodule
`default_nettype wire

// ----- rtl/target_range_bearing_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// target_range_bearing_top
// Range, bearing and circle membership of a query point against a
// configured circle.
// ----------------------------------------------------------------------------
// One word is taken every cycle while the output queue has room. A result
// passes five front-end stages, a chain of 32 cells that each resolve one
// square-root digit (cells below CORDIC_STEPS also one rotation step), one
// formatting stage and the output register. Configuration writes take
// effect at once and belong to idle periods.
// ----------------------------------------------------------------------------
module target_range_bearing_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [62:0]  i_cfg_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [79:0]  i_s_axis_tdata,   // pos_x, pos_y, expansion
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata    // inside_res, distance_squared, distance, bearing
);
    import trb_pkg::*;

    logic signed [31:0] r_center_x, r_center_y;
    logic [62:0]        r_radius_squared;
    logic               adv;
    t_word              chain [SQ_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x       <= '0;
            r_center_y       <= '0;
            r_radius_squared <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X:       r_center_x       <= $signed(i_cfg_data[31:0]);
                CFG_CENTER_Y:       r_center_y       <= $signed(i_cfg_data[31:0]);
                CFG_RADIUS_SQUARED: r_radius_squared <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = adv;

    trb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (adv),
        .i_valid          (i_s_axis_tvalid),
        .i_pos_x          ($signed(i_s_axis_tdata[31:0])),
        .i_pos_y          ($signed(i_s_axis_tdata[63:32])),
        .i_expansion      (i_s_axis_tdata[79:64]),
        .i_center_x       (r_center_x),
        .i_center_y       (r_center_y),
        .i_radius_squared (r_radius_squared),
        .o_w              (chain[0])
    );

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_cell
        trb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_idx   (5'(g)),
            .i_w     (chain[g]),
            .o_w     (chain[g+1])
        );
    end

    trb_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_w     (chain[SQ_STEPS]),
        .o_adv   (adv),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule
`default_nettype wire
